// File: rtl/ica_pkg.sv
// Shared types, constants and the CORDIC angle table for the IMU attitude unit.
// Used by ica_ctrl, ica_dp, the top level and the checker; depends on nothing.
`default_nettype none
package ica_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SMOOTH_FRAC_DEF  = 16;

    localparam int FIELD_W    = 16;
    localparam int ANG_W      = 40;
    localparam int ATN_W      = 34;
    localparam int CRD_W      = 36;
    localparam int MUL_A_W    = 41;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = 59;
    localparam int SUM_W      = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_COEF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_COEF    = 3'd5;

    localparam logic [1:0] YAW_MODE_SLOW = 2'd1;
    localparam logic [1:0] YAW_MODE_FAST = 2'd2;

    localparam logic signed [MUL_B_W-1:0] CENTIDEG_HALF_TURN = 18'sd18000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CINIT, ST_CITER, ST_GMUL, ST_INNER, ST_WMUL, ST_BLEND,
        ST_CMUL, ST_HELD, ST_SMUL, ST_SACC, ST_SUPD, ST_SHELD, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        AX_PITCH, AX_ROLL, AX_YAW
    } t_axis;

    typedef enum logic [2:0] {
        MOP_NONE, MOP_GYRO, MOP_ACC, MOP_GW, MOP_CONV, MOP_SOLD, MOP_SNEW
    } t_mop;

    typedef enum logic [3:0] {
        ACT_NONE, ACT_LOAD, ACT_CINIT, ACT_CITER, ACT_INNER, ACT_ACC,
        ACT_BLEND, ACT_RANGE, ACT_HELD, ACT_SUPD, ACT_SHELD, ACT_OUT
    } t_act;

    typedef struct packed {
        t_mop  mop;
        t_act  act;
        t_axis axis;
    } t_cmd;

    typedef struct packed {
        logic cordic_last;
        logic yaw_off;
    } t_sts;

    // arctan(2^-i) in units of pi/2^31
    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h20000000;
            5'd1:  v = 30'h12E4051E;
            5'd2:  v = 30'h09FB385B;
            5'd3:  v = 30'h051111D4;
            5'd4:  v = 30'h028B0D43;
            5'd5:  v = 30'h0145D7E1;
            5'd6:  v = 30'h00A2F61E;
            5'd7:  v = 30'h00517C55;
            5'd8:  v = 30'h0028BE53;
            5'd9:  v = 30'h00145F2F;
            5'd10: v = 30'h000A2F98;
            5'd11: v = 30'h000517CC;
            5'd12: v = 30'h00028BE6;
            5'd13: v = 30'h000145F3;
            5'd14: v = 30'h0000A2FA;
            5'd15: v = 30'h0000517D;
            5'd16: v = 30'h000028BE;
            5'd17: v = 30'h0000145F;
            5'd18: v = 30'h00000A30;
            5'd19: v = 30'h00000518;
            5'd20: v = 30'h0000028C;
            5'd21: v = 30'h00000146;
            5'd22: v = 30'h000000A3;
            5'd23: v = 30'h00000051;
            5'd24: v = 30'h00000029;
            5'd25: v = 30'h00000014;
            5'd26: v = 30'h0000000A;
            5'd27: v = 30'h00000005;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            5'd30: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/ica_ctrl.sv
// Sequencer for the IMU attitude unit: steps the datapath through CORDIC,
// blend, conversion and low-pass per axis, and owns both handshakes. Uses ica_pkg.
`default_nettype none
module ica_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    input  wire ica_pkg::t_sts i_sts,
    output ica_pkg::t_cmd      o_cmd
);

    ica_pkg::t_state r_state, n_state;
    ica_pkg::t_axis  r_axis, n_axis;
    logic            r_ovalid, n_ovalid;
    logic            out_free;

    assign out_free    = !r_ovalid || !i_out_stall;
    assign o_in_stall  = (r_state != ica_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ica_pkg::ST_IDLE;
            r_axis   <= ica_pkg::AX_PITCH;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_axis   <= n_axis;
            r_ovalid <= n_ovalid;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_axis   = r_axis;
        n_ovalid = r_ovalid && i_out_stall;
        case (r_state)
            ica_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ica_pkg::ST_CINIT;
                    n_axis  = ica_pkg::AX_PITCH;
                end
            end
            ica_pkg::ST_CINIT: n_state = ica_pkg::ST_CITER;
            ica_pkg::ST_CITER: begin
                if (i_sts.cordic_last) n_state = ica_pkg::ST_GMUL;
            end
            ica_pkg::ST_GMUL:  n_state = ica_pkg::ST_INNER;
            ica_pkg::ST_INNER: begin
                // yaw has no accelerometer term
                n_state = (r_axis == ica_pkg::AX_YAW) ? ica_pkg::ST_CMUL : ica_pkg::ST_WMUL;
            end
            ica_pkg::ST_WMUL:  n_state = ica_pkg::ST_BLEND;
            ica_pkg::ST_BLEND: n_state = ica_pkg::ST_CMUL;
            ica_pkg::ST_CMUL:  n_state = ica_pkg::ST_HELD;
            ica_pkg::ST_HELD: begin
                case (r_axis)
                    ica_pkg::AX_PITCH: begin
                        n_state = ica_pkg::ST_CINIT;
                        n_axis  = ica_pkg::AX_ROLL;
                    end
                    ica_pkg::AX_ROLL: begin
                        n_state = ica_pkg::ST_GMUL;
                        n_axis  = ica_pkg::AX_YAW;
                    end
                    default: begin
                        n_state = ica_pkg::ST_SMUL;
                        n_axis  = ica_pkg::AX_PITCH;
                    end
                endcase
            end
            ica_pkg::ST_SMUL:  n_state = ica_pkg::ST_SACC;
            ica_pkg::ST_SACC:  n_state = ica_pkg::ST_SUPD;
            ica_pkg::ST_SUPD:  n_state = ica_pkg::ST_SHELD;
            ica_pkg::ST_SHELD: begin
                case (r_axis)
                    ica_pkg::AX_PITCH: begin
                        n_state = ica_pkg::ST_SMUL;
                        n_axis  = ica_pkg::AX_ROLL;
                    end
                    ica_pkg::AX_ROLL: begin
                        n_state = i_sts.yaw_off ? ica_pkg::ST_DONE : ica_pkg::ST_SMUL;
                        n_axis  = ica_pkg::AX_YAW;
                    end
                    default: n_state = ica_pkg::ST_DONE;
                endcase
            end
            ica_pkg::ST_DONE: begin
                // hold the word until the output register is free
                if (out_free) begin
                    n_state  = ica_pkg::ST_IDLE;
                    n_ovalid = 1'b1;
                end
            end
            default: n_state = ica_pkg::ST_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd.mop  = ica_pkg::MOP_NONE;
        o_cmd.act  = ica_pkg::ACT_NONE;
        o_cmd.axis = r_axis;
        case (r_state)
            ica_pkg::ST_IDLE: begin
                if (i_in_valid) o_cmd.act = ica_pkg::ACT_LOAD;
            end
            ica_pkg::ST_CINIT: o_cmd.act = ica_pkg::ACT_CINIT;
            ica_pkg::ST_CITER: o_cmd.act = ica_pkg::ACT_CITER;
            ica_pkg::ST_GMUL:  o_cmd.mop = ica_pkg::MOP_GYRO;
            ica_pkg::ST_INNER: begin
                o_cmd.act = ica_pkg::ACT_INNER;
                o_cmd.mop = ica_pkg::MOP_ACC;
            end
            ica_pkg::ST_WMUL: begin
                o_cmd.act = ica_pkg::ACT_ACC;
                o_cmd.mop = ica_pkg::MOP_GW;
            end
            ica_pkg::ST_BLEND: o_cmd.act = ica_pkg::ACT_BLEND;
            ica_pkg::ST_CMUL: begin
                o_cmd.act = ica_pkg::ACT_RANGE;
                o_cmd.mop = ica_pkg::MOP_CONV;
            end
            ica_pkg::ST_HELD:  o_cmd.act = ica_pkg::ACT_HELD;
            ica_pkg::ST_SMUL:  o_cmd.mop = ica_pkg::MOP_SOLD;
            ica_pkg::ST_SACC: begin
                o_cmd.act = ica_pkg::ACT_ACC;
                o_cmd.mop = ica_pkg::MOP_SNEW;
            end
            ica_pkg::ST_SUPD:  o_cmd.act = ica_pkg::ACT_SUPD;
            ica_pkg::ST_SHELD: o_cmd.act = ica_pkg::ACT_SHELD;
            ica_pkg::ST_DONE: begin
                if (out_free) o_cmd.act = ica_pkg::ACT_OUT;
            end
            default: o_cmd.act = ica_pkg::ACT_NONE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/ica_dp.sv
// Datapath of the IMU attitude unit: configuration registers, iterative CORDIC,
// one shared registered multiplier, angle/held/low-pass state and output register.
// Uses ica_pkg; driven by ica_ctrl commands.
`default_nettype none
module ica_dp #(
    parameter int CORDIC_STEPS     = ica_pkg::CORDIC_STEPS_DEF,
    parameter int SMOOTH_FRAC_BITS = ica_pkg::SMOOTH_FRAC_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire ica_pkg::t_cmd                         i_cmd,
    output ica_pkg::t_sts                              o_sts,
    input  wire logic                                  i_cfg_we,
    input  wire logic        [ica_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [ica_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_accel_x,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_accel_y,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_accel_z,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_rate_x,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_rate_y,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_rate_z,
    output logic signed      [ica_pkg::FIELD_W-1:0]    o_pitch_centideg,
    output logic signed      [ica_pkg::FIELD_W-1:0]    o_roll_centideg,
    output logic signed      [ica_pkg::FIELD_W-1:0]    o_yaw_centideg
);

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int AW    = ica_pkg::ANG_W;
    localparam int PW    = ica_pkg::PROD_W;
    localparam int SW    = ica_pkg::SUM_W;
    localparam logic signed [SW-1:0] SUM_MAX = 60'sd549755813887;
    localparam logic signed [SW-1:0] SUM_MIN = -SUM_MAX - 60'sd1;
    localparam logic signed [AW-1:0] ANG_HALF = 40'sd2147483648;

    function automatic logic signed [AW-1:0] sat40(input logic signed [SW-1:0] v);
        logic signed [AW-1:0] r;
        if (v > SUM_MAX)      r = SUM_MAX[AW-1:0];
        else if (v < SUM_MIN) r = SUM_MIN[AW-1:0];
        else                  r = v[AW-1:0];
        return r;
    endfunction

    // configuration
    logic [15:0] r_accel_weight, r_gyro_weight, r_slow_coef, r_fast_coef;
    logic [23:0] r_gyro_step;
    logic [1:0]  r_yaw_mode;

    // sample
    logic signed [15:0] r_ax, r_ay, r_az;
    logic signed [16:0] r_rp, r_rr, r_ry;

    // CORDIC
    logic signed [ica_pkg::CRD_W-1:0] r_cx, r_cy;
    logic signed [ica_pkg::ATN_W-1:0] r_cz;
    logic        [CNT_W-1:0]          r_ci;
    logic                             r_zero;

    // arithmetic
    logic signed [PW-1:0] r_prod, r_acc;
    logic signed [AW-1:0] r_inner;
    logic                 r_inr;

    // state
    logic signed [AW-1:0] r_ang  [3];
    logic signed [15:0]   r_held [3];
    logic signed [31:0]   r_sm   [3];

    logic signed [15:0] r_out_p, r_out_r, r_out_y;

    // combinational helpers
    logic signed [ica_pkg::MUL_A_W-1:0] mul_a;
    logic signed [ica_pkg::MUL_B_W-1:0] mul_b;
    logic signed [16:0]                 rate_sel;
    logic [15:0]                        coef_sel;
    logic signed [ica_pkg::ATN_W-1:0]   atn;
    logic signed [AW-1:0]               ang_sel;
    logic signed [31:0]                 sm_sel;
    logic signed [15:0]                 held_sel;
    logic signed [SW-1:0]               sum_wide, sum_shift, inner_sum;
    logic signed [AW-1:0]               inner_sat;
    logic signed [ica_pkg::MUL_A_W-1:0] held_ext;
    logic signed [16:0]                 x0, y0;
    logic signed [ica_pkg::CRD_W-1:0]   xs, ys, xsh, ysh;
    logic signed [ica_pkg::ATN_W-1:0]   tab;
    logic signed [PW-1:0]               conv_adj;
    logic signed [32:0]                 sm_adj;
    logic                               is_yaw;

    assign is_yaw   = (i_cmd.axis == ica_pkg::AX_YAW);
    assign ang_sel  = r_ang[i_cmd.axis];
    assign sm_sel   = r_sm[i_cmd.axis];
    assign held_sel = r_held[i_cmd.axis];
    assign atn      = r_zero ? '0 : r_cz;

    assign o_sts.cordic_last = (r_ci == CNT_W'(CORDIC_STEPS - 1));
    assign o_sts.yaw_off     = (r_yaw_mode != ica_pkg::YAW_MODE_SLOW) &&
                               (r_yaw_mode != ica_pkg::YAW_MODE_FAST);

    always_comb begin
        case (i_cmd.axis)
            ica_pkg::AX_PITCH: rate_sel = r_rp;
            ica_pkg::AX_ROLL:  rate_sel = r_rr;
            default:           rate_sel = r_ry;
        endcase
        coef_sel = (is_yaw && r_yaw_mode == ica_pkg::YAW_MODE_SLOW) ? r_slow_coef : r_fast_coef;
    end

    // operand select for the shared multiplier
    always_comb begin
        held_ext = ica_pkg::MUL_A_W'(held_sel) <<< SMOOTH_FRAC_BITS;
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mop)
            ica_pkg::MOP_GYRO: begin
                mul_a = $signed({17'd0, r_gyro_step});
                mul_b = ica_pkg::MUL_B_W'(rate_sel);
            end
            ica_pkg::MOP_ACC: begin
                mul_a = ica_pkg::MUL_A_W'(atn);
                mul_b = $signed({2'b00, r_accel_weight});
            end
            ica_pkg::MOP_GW: begin
                mul_a = ica_pkg::MUL_A_W'(r_inner);
                mul_b = $signed({2'b00, r_gyro_weight});
            end
            ica_pkg::MOP_CONV: begin
                mul_a = ica_pkg::MUL_A_W'($signed(ang_sel[31:0]));
                mul_b = ica_pkg::CENTIDEG_HALF_TURN;
            end
            ica_pkg::MOP_SOLD: begin
                mul_a = ica_pkg::MUL_A_W'(sm_sel);
                mul_b = $signed({1'b0, 17'(17'd65536 - {1'b0, coef_sel})});
            end
            ica_pkg::MOP_SNEW: begin
                mul_a = held_ext;
                mul_b = $signed({2'b00, coef_sel});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // adders, shifts and saturation
    always_comb begin
        sum_wide  = SW'(r_acc) + SW'(r_prod);
        sum_shift = sum_wide >>> 16;
        inner_sum = SW'(ang_sel) + SW'(r_prod);
        inner_sat = sat40(inner_sum);
        // truncate toward zero: bias negatives before the shift
        conv_adj  = r_prod[PW-1] ? (r_prod + PW'(64'h7FFF_FFFF)) : r_prod;
        sm_adj    = sm_sel[31] ? (33'(sm_sel) + 33'((64'd1 << SMOOTH_FRAC_BITS) - 64'd1))
                               : 33'(sm_sel);
        x0  = -17'(r_ax);
        y0  = (i_cmd.axis == ica_pkg::AX_PITCH) ? -17'(r_ay) : -17'(r_az);
        xs  = {ica_pkg::CRD_W'(x0)} <<< 16;
        ys  = {ica_pkg::CRD_W'(y0)} <<< 16;
        xsh = r_cx >>> r_ci;
        ysh = r_cy >>> r_ci;
        tab = ica_pkg::ATN_W'(ica_pkg::atan_entry(5'(r_ci)));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a * mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_weight <= 16'd3277;
            r_gyro_weight  <= 16'd62259;
            r_gyro_step    <= 24'd8351;
            r_yaw_mode     <= 2'd0;
            r_slow_coef    <= 16'd8192;
            r_fast_coef    <= 16'd16384;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ica_pkg::REG_ACCEL_WEIGHT: r_accel_weight <= i_cfg_data[15:0];
                ica_pkg::REG_GYRO_WEIGHT:  r_gyro_weight  <= i_cfg_data[15:0];
                ica_pkg::REG_GYRO_STEP:    r_gyro_step    <= i_cfg_data[23:0];
                ica_pkg::REG_YAW_MODE:     r_yaw_mode     <= i_cfg_data[1:0];
                ica_pkg::REG_SLOW_COEF:    r_slow_coef    <= i_cfg_data[15:0];
                ica_pkg::REG_FAST_COEF:    r_fast_coef    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_ang[k]  <= '0;
                r_held[k] <= '0;
                r_sm[k]   <= '0;
            end
        end else begin
            case (i_cmd.act)
                ica_pkg::ACT_INNER: begin
                    if (is_yaw) r_ang[i_cmd.axis] <= inner_sat;
                end
                ica_pkg::ACT_BLEND: r_ang[i_cmd.axis] <= sat40(sum_shift);
                ica_pkg::ACT_HELD: begin
                    if (r_inr) r_held[i_cmd.axis] <= 16'(conv_adj >>> 31);
                end
                ica_pkg::ACT_SUPD:  r_sm[i_cmd.axis] <= sum_shift[31:0];
                ica_pkg::ACT_SHELD: r_held[i_cmd.axis] <= 16'(sm_adj >>> SMOOTH_FRAC_BITS);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.act)
            ica_pkg::ACT_LOAD: begin
                r_ax <= i_accel_x;
                r_ay <= i_accel_y;
                r_az <= i_accel_z;
                r_rp <= -17'(i_rate_z);
                r_rr <= 17'(i_rate_y);
                // drop the gyro bias on negative x rates
                r_ry <= i_rate_x[15] ? (17'(i_rate_x) + 17'sd1) : 17'(i_rate_x);
            end
            ica_pkg::ACT_CINIT: begin
                r_zero <= (x0 == '0) && (y0 == '0);
                r_ci   <= '0;
                if (xs[ica_pkg::CRD_W-1]) begin
                    if (!ys[ica_pkg::CRD_W-1]) begin
                        r_cx <= ys;
                        r_cy <= -xs;
                        r_cz <= 34'sd1073741824;
                    end else begin
                        r_cx <= -ys;
                        r_cy <= xs;
                        r_cz <= -34'sd1073741824;
                    end
                end else begin
                    r_cx <= xs;
                    r_cy <= ys;
                    r_cz <= '0;
                end
            end
            ica_pkg::ACT_CITER: begin
                r_ci <= r_ci + CNT_W'(1);
                if (!r_cy[ica_pkg::CRD_W-1]) begin
                    r_cx <= r_cx + ysh;
                    r_cy <= r_cy - xsh;
                    r_cz <= r_cz + tab;
                end else begin
                    r_cx <= r_cx - ysh;
                    r_cy <= r_cy + xsh;
                    r_cz <= r_cz - tab;
                end
            end
            ica_pkg::ACT_INNER: r_inner <= inner_sat;
            ica_pkg::ACT_ACC:   r_acc   <= r_prod;
            ica_pkg::ACT_RANGE: r_inr   <= (ang_sel > -ANG_HALF) && (ang_sel < ANG_HALF);
            ica_pkg::ACT_OUT: begin
                r_out_p <= r_held[ica_pkg::AX_PITCH];
                r_out_r <= r_held[ica_pkg::AX_ROLL];
                r_out_y <= r_held[ica_pkg::AX_YAW];
            end
            default: ;
        endcase
    end

    assign o_pitch_centideg = r_out_p;
    assign o_roll_centideg  = r_out_r;
    assign o_yaw_centideg   = r_out_y;

endmodule
`default_nettype wire

// File: rtl/imu_complementary_attitude_unit.sv
// Top level of the IMU complementary attitude unit: joins ica_ctrl and ica_dp.
// Uses ica_pkg.
`default_nettype none
// One sample in, one pitch/roll/yaw word out. The unit works on one sample at a
// time and returns to idle once the result is loaded, before the next sample is
// taken; the yaw low-pass stage is skipped when it is off. Two CORDIC atan2
// passes, one step per cycle, and the single shared 41x18 multiplier set the
// processing time. The result sits in an output register, so a new sample is
// taken while the previous word still waits to be read.
module imu_complementary_attitude_unit #(
    parameter int CORDIC_STEPS     = ica_pkg::CORDIC_STEPS_DEF,
    parameter int SMOOTH_FRAC_BITS = ica_pkg::SMOOTH_FRAC_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_accel_x,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_accel_y,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_accel_z,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_rate_x,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_rate_y,
    input  wire logic signed [ica_pkg::FIELD_W-1:0]    i_rate_z,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed      [ica_pkg::FIELD_W-1:0]    o_pitch_centideg,
    output logic signed      [ica_pkg::FIELD_W-1:0]    o_roll_centideg,
    output logic signed      [ica_pkg::FIELD_W-1:0]    o_yaw_centideg,
    input  wire logic                                  i_cfg_we,
    input  wire logic        [ica_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [ica_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ica_pkg::t_cmd cmd;
    ica_pkg::t_sts sts;

    ica_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    ica_dp #(
        .CORDIC_STEPS     (CORDIC_STEPS),
        .SMOOTH_FRAC_BITS (SMOOTH_FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_rate_x         (i_rate_x),
        .i_rate_y         (i_rate_y),
        .i_rate_z         (i_rate_z),
        .o_pitch_centideg (o_pitch_centideg),
        .o_roll_centideg  (o_roll_centideg),
        .o_yaw_centideg   (o_yaw_centideg)
    );

endmodule
`default_nettype wire

// File: rtl/ica_checker.sv
// Port-level checks for imu_complementary_attitude_unit, bound to the top level.
// Uses ica_pkg for widths.
`default_nettype none
module ica_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_in_valid,
    input wire logic                                  o_in_stall,
    input wire logic                                  o_out_valid,
    input wire logic                                  i_out_stall,
    input wire logic signed [ica_pkg::FIELD_W-1:0]    o_pitch_centideg,
    input wire logic signed [ica_pkg::FIELD_W-1:0]    o_roll_centideg,
    input wire logic signed [ica_pkg::FIELD_W-1:0]    o_yaw_centideg
);

    // a word held back keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pitch_centideg)
            && $stable(o_roll_centideg) && $stable(o_yaw_centideg))
        else $error("stalled output word changed");

    // an accepted sample keeps the input side busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accepting a sample");

    // a new word cannot appear in the cycle right after a sample is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result appeared without processing time");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pitch_centideg <= 16'sd18000) && (o_pitch_centideg >= -16'sd18000)
            && (o_roll_centideg <= 16'sd18000) && (o_roll_centideg >= -16'sd18000)
            && (o_yaw_centideg <= 16'sd18000) && (o_yaw_centideg >= -16'sd18000))
        else $error("output angle outside half turn");

endmodule

bind imu_complementary_attitude_unit ica_checker u_ica_checker (.*);
`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for imu_complementary_attitude_unit: directed and random
// IMU samples, scored against an in-bench fixed-point attitude predictor.
// Depends on rtl/ica_pkg.sv and rtl/imu_complementary_attitude_unit.sv.
`default_nettype none
module tb;

    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  LONG_HOLD   = 400;
    localparam longint ANG_HI   = 64'sd549755813887;
    localparam longint ANG_LO   = -64'sd549755813888;
    localparam longint HALF_PI2 = 64'sd2147483648;
    localparam longint ATAN_TAB [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    typedef struct packed {
        logic signed [ica_pkg::FIELD_W-1:0] pitch;
        logic signed [ica_pkg::FIELD_W-1:0] roll;
        logic signed [ica_pkg::FIELD_W-1:0] yaw;
    } t_attitude;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [ica_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ica_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic signed [ica_pkg::FIELD_W-1:0] i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic signed [ica_pkg::FIELD_W-1:0] i_rate_x = '0, i_rate_y = '0, i_rate_z = '0;
    logic o_in_stall, o_out_valid;
    logic signed [ica_pkg::FIELD_W-1:0] o_pitch_centideg, o_roll_centideg, o_yaw_centideg;

    imu_complementary_attitude_unit uut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state and register copies
    longint w_acc = 3277, w_gyro = 62259, g_step = 8351, yaw_mode = 0;
    longint slow_c = 8192, fast_c = 16384;
    longint pitch_ang = 0, roll_ang = 0, yaw_ang = 0;
    longint pitch_out = 0, roll_out = 0, yaw_out = 0;
    longint pitch_lp = 0, roll_lp = 0, yaw_lp = 0;

    t_attitude attitude_q [$];
    int errors = 0;
    int words_seen = 0;
    int samples_sent = 0;
    int cycles = 0;
    int hold_req = 0;

    function automatic longint sat40(input longint v);
        if (v > ANG_HI) return ANG_HI;
        if (v < ANG_LO) return ANG_LO;
        return v;
    endfunction

    function automatic longint trunc_shift(input longint x, input int n);
        if (x >= 0) return x >>> n;
        return -((-x) >>> n);
    endfunction

    function automatic longint vector_angle(input longint yi, input longint xi);
        longint x, y, z, t, xs, ys;
        if (xi == 0 && yi == 0) return 0;
        x = xi * 65536;
        y = yi * 65536;
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = HALF_PI2 / 2;
            end else begin
                x = -y; y = t; z = -HALF_PI2 / 2;
            end
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint fuse(input longint ang, input longint acc, input longint rate);
        longint inner;
        inner = sat40(ang + rate * g_step);
        return sat40((w_acc * acc + w_gyro * inner) >>> 16);
    endfunction

    function automatic void to_centideg(input longint ang, inout longint held);
        if (ang > -HALF_PI2 && ang < HALF_PI2) held = trunc_shift(ang * 18000, 31);
    endfunction

    function automatic void low_pass(inout longint s, inout longint held, input longint c);
        s = (s * (65536 - c) + (held <<< 16) * c) >>> 16;
        held = trunc_shift(s, 16);
    endfunction

    function automatic t_attitude predict_attitude(input longint ax, ay, az, gx, gy, gz);
        t_attitude r;
        if (gx < 0) gx = gx + 1;
        pitch_ang = fuse(pitch_ang, vector_angle(-ay, -ax), -gz);
        to_centideg(pitch_ang, pitch_out);
        roll_ang = fuse(roll_ang, vector_angle(-az, -ax), gy);
        to_centideg(roll_ang, roll_out);
        yaw_ang = sat40(yaw_ang + gx * g_step);
        to_centideg(yaw_ang, yaw_out);
        low_pass(pitch_lp, pitch_out, fast_c);
        low_pass(roll_lp, roll_out, fast_c);
        if (yaw_mode == ica_pkg::YAW_MODE_SLOW) low_pass(yaw_lp, yaw_out, slow_c);
        else if (yaw_mode == ica_pkg::YAW_MODE_FAST) low_pass(yaw_lp, yaw_out, fast_c);
        r.pitch = pitch_out[ica_pkg::FIELD_W-1:0];
        r.roll  = roll_out[ica_pkg::FIELD_W-1:0];
        r.yaw   = yaw_out[ica_pkg::FIELD_W-1:0];
        return r;
    endfunction

    // sender: valid stays high across back-to-back words, lowered only for a gap
    task automatic send_sample(input logic signed [ica_pkg::FIELD_W-1:0] ax, ay, az, gx, gy, gz,
                               input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_accel_x <= ax; i_accel_y <= ay; i_accel_z <= az;
        i_rate_x <= gx; i_rate_y <= gy; i_rate_z <= gz;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        attitude_q.push_back(predict_attitude(ax, ay, az, gx, gy, gz));
        samples_sent++;
    endtask

    task automatic send_random(input int n);
        logic signed [ica_pkg::FIELD_W-1:0] f [6];
        for (int k = 0; k < n; k++) begin
            foreach (f[j]) begin
                case ($urandom_range(0, 9))
                    0: f[j] = 16'sh7FFF;
                    1: f[j] = 16'sh8000;
                    2: f[j] = 16'($urandom_range(0, 15) - 8);
                    3, 4: f[j] = 16'($urandom_range(0, 1023) - 512);
                    default: f[j] = 16'($urandom);
                endcase
            end
            send_sample(f[0], f[1], f[2], f[3], f[4], f[5]);
        end
    endtask

    // drop valid, wait out every pending word, let the unit settle
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (attitude_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ica_pkg::CFG_IDX_W-1:0] idx, input longint val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[ica_pkg::CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            ica_pkg::REG_ACCEL_WEIGHT: w_acc = val & 16'hFFFF;
            ica_pkg::REG_GYRO_WEIGHT:  w_gyro = val & 16'hFFFF;
            ica_pkg::REG_GYRO_STEP:    g_step = val & 24'hFFFFFF;
            ica_pkg::REG_YAW_MODE:     yaw_mode = val & 3;
            ica_pkg::REG_SLOW_COEF:    slow_c = val & 16'hFFFF;
            ica_pkg::REG_FAST_COEF:    fast_c = val & 16'hFFFF;
            default: ;
        endcase
    endtask

    task automatic configure(input longint aw, gw, st, md, sc, fc);
        drain();
        write_reg(ica_pkg::REG_ACCEL_WEIGHT, aw);
        write_reg(ica_pkg::REG_GYRO_WEIGHT, gw);
        write_reg(ica_pkg::REG_GYRO_STEP, st);
        write_reg(ica_pkg::REG_YAW_MODE, md);
        write_reg(ica_pkg::REG_SLOW_COEF, sc);
        write_reg(ica_pkg::REG_FAST_COEF, fc);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_directed_defaults;
        send_sample(0, 0, 0, 0, 0, 0);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_sample(-1000, 500, -500, -1, 1, -1);
        send_sample(1000, 500, -500, 1, -1, 1);
        send_sample(16'sh8000, 0, 16'sh7FFF, -1, 0, 0);
        send_sample(0, 16'sh8000, 16'sh7FFF, 0, 16'sh8000, 16'sh7FFF);
        send_sample(0, 0, 0, 0, 0, 0);
    endtask

    // huge step pushes angles past a half turn, so outputs freeze and refilter
    task automatic test_out_of_range;
        configure(65535, 65535, 24'hFFFFFF, 2, 65535, 65535);
        for (int k = 0; k < 6; k++)
            send_sample(-100, 50, -50, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        send_sample(-100, -50, 50, 16'sh8000, 16'sh8000, 16'sh7FFF);
        configure(0, 0, 0, 3, 0, 0);
        send_sample(123, -456, 789, -2, 3, -4);
        send_sample(16'sh7FFF, 16'sh8000, 0, 5, 5, 5);
        // writes past the register list must be ignored
        drain();
        write_reg(3'd6, 24'hFFFFFF);
        write_reg(3'd7, 24'h123456);
        i_cfg_we <= 1'b0;
        send_sample(-7, 9, -11, 13, -15, 17);
    endtask

    task automatic test_backpressure;
        drain();
        hold_req = 1;
        for (int k = 0; k < 10; k++)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 1);
    endtask

    task automatic test_random_settings;
        configure(3277, 62259, 8351, 1, 8192, 16384);
        send_random(220);
        configure(65535, 0, 1, 2, 0, 65535);
        send_random(180);
        configure(0, 65535, 24'hFFFFFF, 0, 65535, 0);
        send_random(180);
        configure($urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 200000), 1, $urandom_range(0, 65535),
                  $urandom_range(0, 65535));
        send_random(240);
        configure(6000, 60000, 40000, 2, 30000, 50000);
        send_random(240);
        configure(3277, 62259, 8351, 3, 8192, 16384);
        send_random(200);
    endtask

    // result side: per-word stall draw, plus a long hold-off on request
    initial begin : receiver
        int wait_left;
        int hold_left;
        t_attitude exp_w;
        wait_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                words_seen++;
                if (attitude_q.size() == 0) begin
                    $error("unexpected word: pitch %0d roll %0d yaw %0d",
                           o_pitch_centideg, o_roll_centideg, o_yaw_centideg);
                    errors++;
                end else begin
                    exp_w = attitude_q.pop_front();
                    if (o_pitch_centideg !== exp_w.pitch) begin
                        $error("pitch_centideg expected %0d got %0d", exp_w.pitch,
                               o_pitch_centideg);
                        errors++;
                    end
                    if (o_roll_centideg !== exp_w.roll) begin
                        $error("roll_centideg expected %0d got %0d", exp_w.roll,
                               o_roll_centideg);
                        errors++;
                    end
                    if (o_yaw_centideg !== exp_w.yaw) begin
                        $error("yaw_centideg expected %0d got %0d", exp_w.yaw,
                               o_yaw_centideg);
                        errors++;
                    end
                end
                wait_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            end
            if (hold_req != 0) begin
                hold_left = LONG_HOLD;
                hold_req = 0;
            end
            if (hold_left > 0) hold_left--;
            else if (wait_left > 0) wait_left--;
            i_out_stall <= (hold_left > 0) || (wait_left > 0);
        end
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin : run
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_defaults();
        test_out_of_range();
        test_backpressure();
        test_random_settings();
        drain();
        $display("Sent %0d samples, checked %0d attitude words over nine register setups,",
                 samples_sent, words_seen);
        $display("covering field extremes, frozen out-of-range angles, all yaw modes, stalls.");
        if (errors == 0 && attitude_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
